// ----- rtl/core/ekcd_pkg.sv -----
package ekcd_pkg;

  localparam int unsigned KeyCap       = 8;
  localparam int unsigned KeyIdxW      = 3;
  localparam int unsigned NumKeysW     = 4;
  localparam int unsigned TicksW       = 8;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 8;
  localparam int unsigned NumKeysRst   = 2;
  localparam int unsigned WindowTksRst = 2;

  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NUM_KEYS     = 1'b0,
    REG_WINDOW_TICKS = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_CLAIM  = 2'd0,
    KIND_CHORD  = 2'd1,
    KIND_REPLAY = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [KeyIdxW-1:0] key_index_res;
    logic               value;
    logic               last;
  } res_t;

endpackage

// ----- rtl/core/ekcd_if.sv -----
interface ekcd_in_if import ekcd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [KeyIdxW-1:0] key_index;
  logic               key_value;

  modport source (output valid, op, key_index, key_value, input ready);
  modport sink   (input valid, op, key_index, key_value, output ready);
endinterface

interface ekcd_out_if import ekcd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [KeyIdxW-1:0] key_index_res;
  logic               value;
  logic               last;

  modport source (output valid, kind, key_index_res, value, last, input ready);
  modport sink   (input valid, kind, key_index_res, value, last, output ready);
endinterface

// ----- rtl/core/ekcd_out_stage.sv -----
module ekcd_out_stage
  import ekcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  res_t        res_i,
  output logic        free_o,
  ekcd_out_if.source  out_o
);

  logic valid_q;
  res_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && free_o) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.kind          = res_q.kind;
  assign out_o.key_index_res = res_q.key_index_res;
  assign out_o.value         = res_q.value;
  assign out_o.last          = res_q.last;

endmodule

// ----- rtl/core/exclusive_key_chord_detector.sv -----
// channel | dir | payload                               | accepted when
// in_i    | in  | op, key_index, key_value              | valid && ready
// out_o   | out | kind, key_index_res, value, last      | valid && ready
// cfg     | in  | cfg_idx_i, cfg_wdata_i                | cfg_we_i
//
// Watched key event: scan n effective keys, decide, optional chord beat, claim.
// Unwatched key event: claim only. Tick: replay of hit keys when the window expires.
// A single scan counter walks the hit bits for chord and replay, one key per cycle
// unless an output stall holds replay on a hit key; stalls delay every result beat.
// Input is ready only while the sequencer is idle; one registered output beat.
// rst_ni clears all key, window and chord state and restores register defaults.
module exclusive_key_chord_detector
  import ekcd_pkg::*;
#(
  parameter int unsigned MAX_KEYS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ekcd_in_if.sink             in_i,
  ekcd_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned NumSlots = (MAX_KEYS < KeyCap) ? MAX_KEYS : KeyCap;
  localparam int unsigned IdxW     = $clog2(NumSlots);
  localparam int unsigned NW       = $clog2(NumSlots + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_CHORD  = 6'b001000,
    S_CLAIM  = 6'b010000,
    S_REPLAY = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [NumSlots-1:0]   lvl_q, lvl_d;
  logic [NumSlots-1:0]   hit_q, hit_d;
  logic                  win_q, win_d;
  logic                  chord_q, chord_d;
  logic [TicksW-1:0]     ticks_q, ticks_d;
  logic [NumKeysW-1:0]   num_keys_q, num_keys_d;
  logic [TicksW-1:0]     wticks_q, wticks_d;
  logic [IdxW-1:0]       cnt_q, cnt_d;
  logic                  full_q, full_d;
  logic                  emit_q, emit_d;

  logic                  v_q, v_d;
  logic                  old_q, old_d;
  logic [IdxW-1:0]       id_q, id_d;
  logic                  claim_q, claim_d;
  logic                  chord_val_q, chord_val_d;

  logic [NW-1:0]         n_eff;
  logic [IdxW-1:0]       last_idx;
  logic [NumSlots-1:0]   watched;
  logic [NumSlots-1:0]   above;
  logic                  key_ok;
  logic [IdxW-1:0]       id_slot;
  logic                  push;
  logic                  out_free;
  res_t                  res;

  always_comb begin
    if (num_keys_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(num_keys_q) > NumSlots) begin
      n_eff = NW'(NumSlots);
    end else begin
      n_eff = NW'(num_keys_q);
    end
  end

  assign last_idx = IdxW'(n_eff - NW'(1));
  assign key_ok   = 32'(in_i.key_index) < 32'(n_eff);
  assign id_slot  = in_i.key_index[IdxW-1:0];

  always_comb begin
    for (int j = 0; j < NumSlots; j++) begin
      watched[j] = NW'(j) < n_eff;
      above[j]   = IdxW'(j) > cnt_q;
    end
  end

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    hit_d       = hit_q;
    win_d       = win_q;
    chord_d     = chord_q;
    ticks_d     = ticks_q;
    num_keys_d  = num_keys_q;
    wticks_d    = wticks_q;
    cnt_d       = cnt_q;
    full_d      = full_q;
    emit_d      = emit_q;
    v_d         = v_q;
    old_d       = old_q;
    id_d        = id_q;
    claim_d     = claim_q;
    chord_val_d = chord_val_q;
    push        = 1'b0;
    res         = '{kind: KIND_CLAIM, key_index_res: '0, value: 1'b0, last: 1'b0};

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NUM_KEYS:     num_keys_d = cfg_wdata_i[NumKeysW-1:0];
        REG_WINDOW_TICKS: wticks_d   = cfg_wdata_i[TicksW-1:0];
        default:          ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.op == OP_TICK) begin
            if (win_q && ticks_q != '0) begin
              ticks_d = ticks_q - TicksW'(1);
            end
            if (win_q && ticks_d == '0) begin
              cnt_d   = '0;
              state_d = S_REPLAY;
            end
          end else if (key_ok) begin
            old_d          = lvl_q[id_slot];
            v_d            = in_i.key_value;
            id_d           = id_slot;
            lvl_d[id_slot] = in_i.key_value;
            if (in_i.key_value != lvl_q[id_slot]) begin
              hit_d[id_slot] = in_i.key_value;
            end
            full_d  = 1'b1;
            cnt_d   = '0;
            state_d = S_SCAN;
          end else begin
            claim_d = 1'b0;
            state_d = S_CLAIM;
          end
        end
      end
      S_SCAN: begin
        full_d = full_q & hit_q[cnt_q];
        if (cnt_q == last_idx) begin
          state_d = S_DECIDE;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      S_DECIDE: begin
        emit_d = 1'b0;
        if (!full_q && !win_q && v_q && !old_q) begin
          win_d       = 1'b1;
          hit_d       = '0;
          hit_d[id_q] = 1'b1;
          ticks_d     = wticks_q;
        end
        if (full_q && !chord_q) begin
          emit_d      = win_q;
          chord_val_d = 1'b1;
          chord_d     = 1'b1;
          win_d       = 1'b0;
        end
        if (!full_q && chord_q) begin
          emit_d      = 1'b1;
          chord_val_d = 1'b0;
          hit_d       = '0;
          chord_d     = 1'b0;
        end
        claim_d = v_q && (chord_d || win_d);
        state_d = emit_d ? S_CHORD : S_CLAIM;
      end
      S_CHORD: begin
        if (out_free) begin
          push    = 1'b1;
          res     = '{kind: KIND_CHORD, key_index_res: '0, value: chord_val_q, last: 1'b0};
          state_d = S_CLAIM;
        end
      end
      S_CLAIM: begin
        if (out_free) begin
          push    = 1'b1;
          res     = '{kind: KIND_CLAIM, key_index_res: '0, value: claim_q, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_REPLAY: begin
        if (!hit_q[cnt_q] || out_free) begin
          if (hit_q[cnt_q]) begin
            push = 1'b1;
            res  = '{kind: KIND_REPLAY, key_index_res: KeyIdxW'(cnt_q),
                     value: lvl_q[cnt_q], last: (hit_q & watched & above) == '0};
          end
          if (cnt_q == last_idx) begin
            hit_d   = '0;
            win_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      lvl_q      <= '0;
      hit_q      <= '0;
      win_q      <= 1'b0;
      chord_q    <= 1'b0;
      ticks_q    <= TicksW'(WindowTksRst);
      num_keys_q <= NumKeysW'(NumKeysRst);
      wticks_q   <= TicksW'(WindowTksRst);
      cnt_q      <= '0;
      full_q     <= 1'b0;
      emit_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      lvl_q      <= lvl_d;
      hit_q      <= hit_d;
      win_q      <= win_d;
      chord_q    <= chord_d;
      ticks_q    <= ticks_d;
      num_keys_q <= num_keys_d;
      wticks_q   <= wticks_d;
      cnt_q      <= cnt_d;
      full_q     <= full_d;
      emit_q     <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    old_q       <= old_d;
    id_q        <= id_d;
    claim_q     <= claim_d;
    chord_val_q <= chord_val_d;
  end

  ekcd_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_chord_window_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(chord_q && win_q))
    else $error("chord held while window open");

  a_replay_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REPLAY && state_d == S_IDLE) |=> (hit_q == '0 && !win_q))
    else $error("replay left hit bits or window set");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_REPLAY) |-> (cnt_q <= last_idx))
    else $error("scan counter beyond watched keys");
`endif

endmodule
